### rtl/core/cdph_pkg.sv
// Shared constants, types and state encoding for the decay-curve peak hold block.
`timescale 1ns / 1ps
package cdph_pkg;

    localparam int FRAME_DEPTH = 64;
    localparam int CURVE_DEPTH = 32;
    localparam int SAMPLE_BITS = 16;

    localparam int FRAME_AW   = $clog2(FRAME_DEPTH);
    localparam int COUNT_W    = FRAME_AW + 1;
    localparam int CURVE_AW   = 5;
    localparam int LEN_W      = 6;
    localparam int FACTOR_W   = 17;
    localparam int PRODUCT_W  = SAMPLE_BITS + FACTOR_W;

    localparam logic [FACTOR_W-1:0]    UNITY      = 17'h10000;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    localparam logic FUNC_CURVE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic REG_CURVE_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_EV,
        ST_BWD_RD,
        ST_BWD_EV,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } cdph_state_t;

    typedef struct packed {
        logic take;
        logic pass_init;
        logic bwd_init;
        logic eval;
        logic pos_inc;
        logic pos_dec;
        logic emit_init;
        logic emit_load;
        logic frame_done;
    } cdph_cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_zero;
        logic out_free;
    } cdph_status_t;

endpackage

### rtl/core/cdph_ctrl.sv
// Sequencer for loading, forward pass, backward pass and frame emission.
`timescale 1ns / 1ps
module cdph_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_func,
    input  logic                  s_last,
    output logic                  s_ready,
    input  cdph_pkg::cdph_status_t status,
    output cdph_pkg::cdph_cmd_t    cmd
);
    import cdph_pkg::*;

    cdph_state_t state_reg;
    cdph_state_t state_next;
    logic        trigger;

    assign trigger = s_valid && (s_func == FUNC_SAMPLE) && s_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (trigger) state_next = ST_FWD_RD;
            end
            ST_FWD_RD:  state_next = ST_FWD_EV;
            ST_FWD_EV: begin
                state_next = status.pos_last ? ST_BWD_RD : ST_FWD_RD;
            end
            ST_BWD_RD:  state_next = ST_BWD_EV;
            ST_BWD_EV: begin
                state_next = status.pos_zero ? ST_EMIT_RD : ST_BWD_RD;
            end
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (status.out_free) begin
                    state_next = status.pos_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.take      = s_valid;
                cmd.pass_init = trigger;
            end
            ST_FWD_EV: begin
                cmd.eval     = 1'b1;
                cmd.pos_inc  = !status.pos_last;
                cmd.bwd_init = status.pos_last;
            end
            ST_BWD_EV: begin
                cmd.eval      = 1'b1;
                cmd.pos_dec   = !status.pos_zero;
                cmd.emit_init = status.pos_zero;
            end
            ST_EMIT_OUT: begin
                cmd.emit_load  = status.out_free;
                cmd.pos_inc    = status.out_free && !status.pos_last;
                cmd.frame_done = status.out_free && status.pos_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/cdph_datapath.sv
// Sample memory, curve store, held peak, decay multiplier and output register.
`timescale 1ns / 1ps
module cdph_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  cdph_pkg::cdph_cmd_t                    cmd,
    output cdph_pkg::cdph_status_t                 status,
    input  logic                                   s_func,
    input  logic [4:0]                             s_index,
    input  logic [16:0]                            s_value,
    input  logic [5:0]                             active_len,
    output logic [cdph_pkg::SAMPLE_BITS-1:0]       m_level,
    output logic                                   m_last_out,
    output logic                                   m_valid,
    input  logic                                   m_ready
);
    import cdph_pkg::*;

    logic [SAMPLE_BITS-1:0] sample_mem [FRAME_DEPTH];
    logic [SAMPLE_BITS-1:0] rdata_reg;

    logic [FACTOR_W-1:0]    curve_reg [CURVE_DEPTH];
    logic [COUNT_W-1:0]     count_reg;
    logic [FRAME_AW-1:0]    pos_reg;
    logic [SAMPLE_BITS-1:0] peak_reg;
    logic [LEN_W-1:0]       dp_reg;
    logic [SAMPLE_BITS-1:0] fall_reg;

    logic [SAMPLE_BITS-1:0] level_reg;
    logic                   last_out_reg;
    logic                   valid_reg;

    logic [SAMPLE_BITS-1:0] sample_in;
    logic [COUNT_W-1:0]     count_m1;
    logic [LEN_W-1:0]       curve_idx;
    logic [FACTOR_W-1:0]    factor;
    logic [PRODUCT_W-1:0]   product;
    logic                   keep;
    logic                   store_en;
    logic                   replace_en;

    assign sample_in = (s_value > {1'b0, SAMPLE_MAX}) ? SAMPLE_MAX
                                                      : s_value[SAMPLE_BITS-1:0];
    assign count_m1  = count_reg - COUNT_W'(1);

    // Curve is read from its end: entry len-1-dp.
    assign curve_idx = active_len - LEN_W'(1) - dp_reg;
    assign factor    = (curve_reg[curve_idx[CURVE_AW-1:0]] > UNITY) ? UNITY
                       : curve_reg[curve_idx[CURVE_AW-1:0]];
    assign product   = PRODUCT_W'(peak_reg) * PRODUCT_W'(factor);

    assign keep = (rdata_reg >= peak_reg) || (dp_reg >= active_len)
               || (rdata_reg >= fall_reg);

    assign store_en   = cmd.take && (s_func == FUNC_SAMPLE) && !count_reg[COUNT_W-1];
    assign replace_en = cmd.eval && !keep;

    always_ff @(posedge aclk) begin
        if (store_en) begin
            sample_mem[count_reg[FRAME_AW-1:0]] <= sample_in;
        end else if (replace_en) begin
            sample_mem[pos_reg] <= fall_reg;
        end
        rdata_reg <= sample_mem[pos_reg];
    end

    // Product is registered; peak and position hold during the read cycle.
    always_ff @(posedge aclk) begin
        fall_reg <= product[SAMPLE_BITS +: SAMPLE_BITS];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CURVE_DEPTH; i++) begin
                curve_reg[i] <= '0;
            end
        end else if (cmd.take && (s_func == FUNC_CURVE)
                     && (32'(s_index) < CURVE_DEPTH)) begin
            curve_reg[s_index[CURVE_AW-1:0]] <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            peak_reg  <= '0;
            dp_reg    <= '0;
        end else begin
            if (cmd.frame_done) begin
                count_reg <= '0;
            end else if (store_en) begin
                count_reg <= count_reg + COUNT_W'(1);
            end

            if (cmd.pass_init || cmd.emit_init) begin
                pos_reg <= '0;
            end else if (cmd.bwd_init) begin
                pos_reg <= count_m1[FRAME_AW-1:0];
            end else if (cmd.pos_inc) begin
                pos_reg <= pos_reg + FRAME_AW'(1);
            end else if (cmd.pos_dec) begin
                pos_reg <= pos_reg - FRAME_AW'(1);
            end

            if (cmd.pass_init || cmd.bwd_init) begin
                peak_reg <= '0;
                dp_reg   <= '0;
            end else if (cmd.eval) begin
                if (keep) begin
                    peak_reg <= rdata_reg;
                    dp_reg   <= '0;
                end else begin
                    dp_reg <= dp_reg + LEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            level_reg    <= rdata_reg;
            last_out_reg <= status.pos_last;
        end
    end

    assign status.pos_last = ({1'b0, pos_reg} == count_m1);
    assign status.pos_zero = (pos_reg == '0);
    assign status.out_free = !valid_reg || m_ready;

    assign m_level    = level_reg;
    assign m_last_out = last_out_reg;
    assign m_valid    = valid_reg;

endmodule

### rtl/core/curve_decay_peak_hold.sv
// Top level of the decay-curve peak hold: register port, sequencer and datapath.
//
//   port      dir   handshake         payload
//   s_*       in    s_valid/s_ready   s_func, s_index, s_value, s_last
//   m_*       out   m_valid/m_ready   m_level, m_last_out
//   p*        cfg   psel/penable      paddr, pwdata, prdata (curve_length at 0x0)
//
// Curve words and non-final samples are taken while the sequencer is idle. A frame
// of n samples then goes through a forward pass, a backward pass and emission, each
// step set by the single-port sample memory with its registered read.
// Reset is synchronous, active low; the sample memory is not cleared.
// A stalled m_ready holds emission; input is refused until the frame is out.
`timescale 1ns / 1ps
module curve_decay_peak_hold (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [4:0]  s_index,
    input  logic [16:0] s_value,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_level,
    output logic        m_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cdph_pkg::*;

    cdph_cmd_t         cmd;
    cdph_status_t      status;
    logic [LEN_W-1:0]  curve_length_reg;
    logic [LEN_W-1:0]  active_len;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_length_reg <= '0;
        end else if (psel && penable && pwrite && (reg_sel == REG_CURVE_LENGTH)) begin
            curve_length_reg <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_CURVE_LENGTH) ? {{(32-LEN_W){1'b0}}, curve_length_reg}
                                                  : '0;

    // Clamp the active length to the curve store depth.
    assign active_len = (32'(curve_length_reg) > CURVE_DEPTH) ? LEN_W'(CURVE_DEPTH)
                                                              : curve_length_reg;

    cdph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_last  (s_last),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cdph_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_func     (s_func),
        .s_index    (s_index),
        .s_value    (s_value),
        .active_len (active_len),
        .m_level    (m_level),
        .m_last_out (m_last_out),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (!m_valid || m_ready))
        else $error("result register loaded while a result is pending");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.eval || cmd.emit_load) |-> !s_ready)
        else $error("input accepted during frame processing");

    a_start_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_init |-> (s_valid && s_ready && (s_func == FUNC_SAMPLE) && s_last))
        else $error("pass started without a final sample");

    a_emit_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_load && status.pos_last) |=> (m_valid && m_last_out))
        else $error("final result not marked");

endmodule

### tb/curve_decay_peak_hold_check.sv
// Checker for the decay-curve peak hold: watches channels and register port, predicts frames.
`timescale 1ns / 1ps
module curve_decay_peak_hold_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_func,
    input  logic [4:0]  s_index,
    input  logic [16:0] s_value,
    input  logic        s_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_level,
    input  logic        m_last_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          outstanding
);
    import cdph_pkg::*;

    localparam logic [2:0] CURVE_LENGTH_ADDR = 3'(4 * REG_CURVE_LENGTH);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] level;
        logic                   last_out;
    } shaped_sample_t;

    shaped_sample_t shaped_q[$];
    shaped_sample_t got;

    logic [FACTOR_W-1:0]    curve_mem [CURVE_DEPTH];
    logic [SAMPLE_BITS-1:0] frame_mem [FRAME_DEPTH];
    logic [LEN_W-1:0]       curve_len;
    logic [SAMPLE_BITS-1:0] peak;
    int unsigned            frame_fill;
    int unsigned            fall_step;
    int unsigned            active_len;

    // Keep the sample as new peak, or replace it by the decayed peak.
    task automatic hold_or_decay(input int unsigned pos, input int unsigned len);
        logic [SAMPLE_BITS-1:0] s;
        logic [FACTOR_W-1:0]    f;
        logic [PRODUCT_W-1:0]   prod;
        logic [SAMPLE_BITS-1:0] fall;
        s = frame_mem[pos];
        if (s >= peak || fall_step >= len) begin
            peak = s;
            fall_step = 0;
        end else begin
            f = curve_mem[len - 1 - fall_step];
            if (f > UNITY) f = UNITY;
            prod = PRODUCT_W'(peak) * PRODUCT_W'(f);
            fall = prod[SAMPLE_BITS+15:16];
            if (s >= fall) begin
                peak = s;
                fall_step = 0;
            end else begin
                frame_mem[pos] = fall;
                fall_step++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            curve_len = '0;
            frame_fill = 0;
            peak = '0;
            fall_step = 0;
            errors = 0;
            for (int i = 0; i < CURVE_DEPTH; i++) curve_mem[i] = '0;
            shaped_q.delete();
            outstanding <= 0;
        end else begin
            if (psel && penable && pready && paddr == CURVE_LENGTH_ADDR) begin
                if (pwrite) begin
                    curve_len = pwdata[LEN_W-1:0];
                end else if (prdata !== 32'(curve_len)) begin
                    $display("%0t: curve_length read expected %h actual %h",
                             $time, 32'(curve_len), prdata);
                    errors = errors + 1;
                end
            end

            if (s_valid && s_ready) begin
                if (s_func == FUNC_CURVE) begin
                    if (int'(s_index) < CURVE_DEPTH) curve_mem[s_index] = s_value;
                end else begin
                    // drop samples past the store depth
                    if (frame_fill < FRAME_DEPTH) begin
                        frame_mem[frame_fill] = (s_value > SAMPLE_MAX) ? SAMPLE_MAX
                                                                       : s_value[SAMPLE_BITS-1:0];
                        frame_fill++;
                    end
                    if (s_last) begin
                        active_len = (int'(curve_len) > CURVE_DEPTH) ? CURVE_DEPTH
                                                                     : int'(curve_len);
                        peak = '0;
                        fall_step = 0;
                        for (int i = 0; i < frame_fill; i++) hold_or_decay(i, active_len);
                        peak = '0;
                        fall_step = 0;
                        for (int i = 0; i < frame_fill; i++)
                            hold_or_decay(frame_fill - 1 - i, active_len);
                        for (int i = 0; i < frame_fill; i++)
                            shaped_q.push_back('{level: frame_mem[i],
                                                 last_out: (i + 1 == frame_fill)});
                        frame_fill = 0;
                    end
                end
            end

            if (m_valid && m_ready) begin
                if (shaped_q.size() == 0) begin
                    $display("%0t: unexpected item expected none actual level %h last_out %b",
                             $time, m_level, m_last_out);
                    errors = errors + 1;
                end else begin
                    got = shaped_q.pop_front();
                    if (m_level !== got.level) begin
                        $display("%0t: level expected %h actual %h", $time, got.level, m_level);
                        errors = errors + 1;
                    end
                    if (m_last_out !== got.last_out) begin
                        $display("%0t: last_out expected %b actual %b",
                                 $time, got.last_out, m_last_out);
                        errors = errors + 1;
                    end
                end
            end

            outstanding <= shaped_q.size();
        end
    end

endmodule

### tb/curve_decay_peak_hold_test.sv
// Top of the peak hold testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module curve_decay_peak_hold_test;
    import cdph_pkg::*;

    localparam logic [2:0] CURVE_LENGTH_ADDR = 3'(4 * REG_CURVE_LENGTH);
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEM_TARGET   = 450;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_func  = FUNC_CURVE;
    logic [4:0]  s_index = '0;
    logic [16:0] s_value = '0;
    logic        s_last  = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_level;
    logic        m_last_out;
    logic [31:0] prdata;
    logic        pready;

    int          errors;
    int          outstanding;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          gaps_on = 1'b1;

    always #2 aclk = ~aclk;

    curve_decay_peak_hold uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_index    (s_index),
        .s_value    (s_value),
        .s_last     (s_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_level    (m_level),
        .m_last_out (m_last_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    curve_decay_peak_hold_check shape_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_index     (s_index),
        .s_value     (s_value),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_last_out  (m_last_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(0, 99) >= 28);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("curve_decay_peak_hold verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic func, input logic [4:0] idx,
                             input logic [16:0] val, input logic last);
        while (gaps_on && $urandom_range(0, 99) < 28) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_index <= idx;
        s_value <= val;
        s_last  <= last;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Hold input until every shaped sample is out, then let the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_curve_length(input logic [31:0] data);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CURVE_LENGTH_ADDR;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pwdata  <= $urandom;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [16:0] random_factor();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 17'd0;
            1: return UNITY;
            2: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(40000, 65535));
        endcase
    endfunction

    function automatic logic [16:0] random_sample(input int style);
        case (style)
            0: return ($urandom_range(0, 4) == 0) ? 17'($urandom_range(20000, 65535))
                                                  : 17'($urandom_range(0, 3000));
            1: return 17'($urandom_range(0, 131071));
            2: return 17'($urandom_range(0, 65535));
            default: begin
                case ($urandom_range(0, 3))
                    0: return 17'd0;
                    1: return 17'd65535;
                    2: return 17'd1000;
                    default: return UNITY;
                endcase
            end
        endcase
    endfunction

    task automatic send_frame(input int n, input int style, input bit noisy);
        for (int i = 0; i < n; i++) begin
            // slip curve words in between samples now and then
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(FUNC_CURVE, 5'($urandom), random_factor(),
                          1'($urandom_range(0, 1)));
            send_item(FUNC_SAMPLE, 5'($urandom), random_sample(style), i == n - 1);
        end
    endtask

    initial begin
        int phase;
        int frame_len;
        logic [LEN_W-1:0] len_sel;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no shaping: single-sample frame, saturation at the top
        send_item(FUNC_SAMPLE, 5'd31, 17'd0, 1'b1);
        send_item(FUNC_SAMPLE, 5'd0, 17'd65535, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, UNITY, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'h1FFFF, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'd0, 1'b1);

        set_curve_length(32'hFFFF_FFC4);
        send_item(FUNC_CURVE, 5'd0, 17'd0, 1'b0);
        send_item(FUNC_CURVE, 5'd1, UNITY, 1'b0);
        send_item(FUNC_CURVE, 5'd2, 17'h1FFFF, 1'b1);
        send_item(FUNC_CURVE, 5'd3, 17'd32768, 1'b0);
        send_item(FUNC_CURVE, 5'd31, 17'd65535, 1'b1);

        // decay through the whole curve, reacquire, saturate, decay again
        send_item(FUNC_SAMPLE, 5'd0, 17'd60000, 1'b0);
        repeat (5) send_item(FUNC_SAMPLE, 5'd0, 17'd100, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'd70000, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'd5, 1'b1);

        // equal samples hold the peak
        send_item(FUNC_SAMPLE, 5'd0, 17'd40000, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'd40000, 1'b0);
        send_item(FUNC_SAMPLE, 5'd0, 17'd20000, 1'b1);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: len_sel = 6'd32;
                1: len_sel = 6'd63;
                2: len_sel = 6'd0;
                3: len_sel = 6'd1;
                default: len_sel = 6'($urandom_range(0, 63));
            endcase
            set_curve_length(($urandom & ~32'h3F) | 32'(len_sel));
            gaps_on = (phase != 4);

            repeat ($urandom_range(4, 16))
                send_item(FUNC_CURVE, 5'($urandom), random_factor(),
                          1'($urandom_range(0, 1)));

            for (int f = 0; f < $urandom_range(3, 6); f++) begin
                if (phase == 1 && f == 0)
                    frame_len = $urandom_range(65, 70);
                else if ($urandom_range(0, 9) == 0)
                    frame_len = $urandom_range(30, 64);
                else
                    frame_len = $urandom_range(1, 10);
                send_frame(frame_len, $urandom_range(0, 3), 1'(phase % 2));
                if (phase == 5) drain();
            end
            phase++;
        end

        gaps_on = 1'b1;
        drain();
        if (errors == 0 && outstanding == 0) begin
            $display("curve_decay_peak_hold verification clean");
        end else begin
            $display("curve_decay_peak_hold verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/cdph_pkg.sv
rtl/core/cdph_ctrl.sv
rtl/core/cdph_datapath.sv
rtl/core/curve_decay_peak_hold.sv
tb/curve_decay_peak_hold_check.sv
tb/curve_decay_peak_hold_test.sv
